// ===== sv/pli_pkg.sv =====
// Package for the piecewise linear interpolator: widths, codes and control types.
// Used by pli_ctrl, pli_dpath and the top level; depends on nothing.
package pli_pkg;

  localparam int MaxPoints = 64;
  localparam int FracBits  = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int LenW      = IdxW + 1;
  localparam int CntW      = 7;
  localparam int DataW     = 32;
  localparam int QuotW     = DataW + FracBits + 1;
  localparam int DivCntW   = $clog2(QuotW + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_ABOVE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_CHECK, S_PROBE, S_PROBE_CMP,
    S_RD_PAIR, S_RD_PAIR2, S_DIV_SETUP, S_DIV, S_MUL, S_SUM, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_first;
    logic rd_last;
    logic classify;
    logic probe_rd;
    logic probe_upd;
    logic rd_lo;
    logic rd_hi;
    logic div_setup;
    logic div_step;
    logic mul;
    logic sum;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early_done;
    logic search_done;
    logic div_done;
  } stat_t;

endpackage

// ===== sv/pli_ctrl.sv =====
// Controller state machine for the interpolator: sequences reads, search,
// division and blend. Depends on pli_pkg.
module pli_ctrl
  import pli_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_stall,
  input  logic  req_type,
  input  logic  out_busy,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid && !in_stall && req_type == REQ_EVAL) state_next = S_RD_FIRST;
      S_RD_FIRST:  state_next = S_RD_LAST;
      S_RD_LAST:   state_next = S_CHECK;
      S_CHECK:     state_next = st.early_done ? S_OUT : S_PROBE;
      S_PROBE:     state_next = st.search_done ? S_RD_PAIR : S_PROBE_CMP;
      S_PROBE_CMP: state_next = S_PROBE;
      S_RD_PAIR:   state_next = S_RD_PAIR2;
      S_RD_PAIR2:  state_next = S_DIV_SETUP;
      S_DIV_SETUP: state_next = S_DIV;
      S_DIV:       if (st.div_done) state_next = S_MUL;
      S_MUL:       state_next = S_SUM;
      S_SUM:       state_next = S_OUT;
      S_OUT:       if (!out_busy) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        cmd.capture = 1'b1;
      end
      S_RD_FIRST:  cmd.rd_first = 1'b1;
      S_RD_LAST:   cmd.rd_last = 1'b1;
      S_CHECK:     cmd.classify = 1'b1;
      S_PROBE:     cmd.probe_rd = !st.search_done;
      S_PROBE_CMP: cmd.probe_upd = 1'b1;
      S_RD_PAIR:   cmd.rd_lo = 1'b1;
      S_RD_PAIR2:  cmd.rd_hi = 1'b1;
      S_DIV_SETUP: cmd.div_setup = 1'b1;
      S_DIV:       cmd.div_step = 1'b1;
      S_MUL:       cmd.mul = 1'b1;
      S_SUM:       cmd.sum = 1'b1;
      S_OUT:       cmd.load_out = !out_busy;
      default:     cmd = '0;
    endcase
  end

endmodule

// ===== sv/pli_dpath.sv =====
// Datapath for the interpolator: breakpoint memories, search registers,
// restoring divider, multipliers and the result register. Depends on pli_pkg.
module pli_dpath
  import pli_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic                    load_we,
  input  logic [IdxW-1:0]         entry_index,
  input  logic signed [DataW-1:0] x_value,
  input  logic signed [DataW-1:0] y_value,
  input  logic [CntW-1:0]         point_count,
  input  logic                    out_stall,
  output stat_t                   st,
  output logic                    out_valid,
  output logic signed [DataW-1:0] y_result,
  output logic [1:0]              status
);

  logic signed [DataW-1:0] x_mem [MaxPoints];
  logic signed [DataW-1:0] y_mem [MaxPoints];
  logic signed [DataW-1:0] x_rd, y_rd;
  logic [IdxW-1:0]         rd_addr;

  logic signed [DataW-1:0] q;
  logic [LenW-1:0]         n;
  logic [LenW-1:0]         first, len;
  logic signed [DataW-1:0] x_first, y_first;
  logic signed [DataW-1:0] x_lo, y_lo, y_hi;
  logic [1:0]              res_status;
  logic signed [DataW-1:0] res_y;
  logic signed [DataW-1:0] res_y_hold;
  logic [1:0]              res_st_hold;
  logic                    early;
  logic [LenW-1:0]         half, mid, idx_c;
  logic                    sel_lo;

  // Divider state.
  logic [DataW:0]          den;
  logic [DataW:0]          rem;
  logic [QuotW-1:0]        quo;
  logic [DivCntW-1:0]      div_cnt;
  logic                    deg;
  logic [FracBits:0]       p;
  logic signed [DataW+FracBits+1:0] prod_lo, prod_hi;
  logic signed [DataW:0]   num_w;
  logic [DataW+1:0]        rem_sh;

  // Read address select.
  always_comb begin
    half  = len >> 1;
    mid   = first + half;
    idx_c = first;
    if (idx_c < LenW'(1)) idx_c = LenW'(1);
    if (idx_c > n - LenW'(1)) idx_c = n - LenW'(1);
    priority if (cmd.rd_first) rd_addr = '0;
    else if (cmd.rd_last)  rd_addr = IdxW'(n - LenW'(1));
    else if (cmd.probe_rd) rd_addr = mid[IdxW-1:0];
    else if (cmd.rd_lo)    rd_addr = IdxW'(idx_c - LenW'(1));
    else if (cmd.rd_hi)    rd_addr = idx_c[IdxW-1:0];
    else                   rd_addr = '0;
  end

  // Breakpoint memories, one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (load_we) begin
      x_mem[entry_index] <= x_value;
      y_mem[entry_index] <= y_value;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  // Classification of the query against the ends of the table.
  always_comb begin
    early = 1'b1;
    res_status = ST_OK;
    res_y = '0;
    priority if (n == '0) res_status = ST_EMPTY;
    else if (q < x_first) res_status = ST_BELOW;
    else if (q > x_rd)    res_status = ST_ABOVE;
    else if (q == x_first) res_y = y_first;
    else if (q == x_rd)    res_y = y_rd;
    else early = 1'b0;
  end

  assign st.early_done  = early;
  assign st.search_done = (len == '0);
  assign st.div_done    = (div_cnt == '0);

  assign num_w  = {q[DataW-1], q} - {x_lo[DataW-1], x_lo};
  assign rem_sh = {rem, quo[QuotW-1]};
  assign sel_lo = cmd.rd_hi;

  // Search, divider and blend registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q <= x_value;
      n <= (point_count > CntW'(MaxPoints)) ? LenW'(MaxPoints) : LenW'(point_count);
    end
    if (cmd.rd_last) begin
      x_first <= x_rd;
      y_first <= y_rd;
    end
    if (cmd.classify) begin
      res_y_hold <= res_y;
      res_st_hold <= res_status;
      first <= '0;
      len <= n;
    end
    if (cmd.probe_upd) begin
      if (x_rd < q) begin
        first <= mid + LenW'(1);
        len   <= len - half - LenW'(1);
      end else begin
        len <= half;
      end
    end
    if (sel_lo) begin
      x_lo <= x_rd;
      y_lo <= y_rd;
    end
    if (cmd.div_setup) begin
      y_hi <= y_rd;
    end
    if (cmd.mul) begin
      prod_lo <= $signed({1'b0, (FracBits+1)'(1 << FracBits) - p}) * y_lo;
      prod_hi <= $signed({1'b0, p}) * y_hi;
    end
    if (cmd.sum) res_y_hold <= DataW'((prod_lo + prod_hi) >>> FracBits);
  end

  // Interval setup and restoring division, one quotient bit per cycle.
  logic signed [DataW:0] den_s;
  assign den_s = {x_rd[DataW-1], x_rd} - {x_lo[DataW-1], x_lo};

  always_ff @(posedge clk) begin
    if (cmd.div_setup) begin
      deg     <= (den_s <= 0);
      den     <= den_s[DataW:0];
      rem     <= '0;
      quo     <= (num_w <= 0) ? '0 : {num_w[DataW-1:0], FracBits'(0), 1'b0} >> 1;
      div_cnt <= DivCntW'(QuotW);
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - DivCntW'(1);
      if (rem_sh >= {1'b0, den}) begin
        rem <= (DataW+1)'(rem_sh - {1'b0, den});
        quo <= {quo[QuotW-2:0], 1'b1};
      end else begin
        rem <= (DataW+1)'(rem_sh);
        quo <= {quo[QuotW-2:0], 1'b0};
      end
    end
    if (cmd.div_step && div_cnt == '0) begin
      if (deg) p <= '0;
      else if (quo > QuotW'(1 << FracBits)) p <= (FracBits+1)'(1 << FracBits);
      else p <= quo[FracBits:0];
    end
  end

  // Output register; parts the block from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      status   <= res_st_hold;
      y_result <= (res_st_hold == ST_OK) ? res_y_hold : '0;
    end
  end

endmodule

// ===== sv/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator over a 64-entry breakpoint table.
// Load items are written straight into the table. Evaluate items whose query is out
// of range or on an end point go straight to the result; others run a binary search
// and a restoring divider before the blend. One item is worked at a time; the
// next item is taken the cycle after the result is loaded.
// rst is synchronous; it clears point_count and control state, not the table.
module piecewise_linear_interpolator
  import pli_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic [IdxW-1:0]         entry_index,
  input  logic signed [DataW-1:0] x_value,
  input  logic signed [DataW-1:0] y_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] y_result,
  output logic [1:0]              status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CntW-1:0]         cfg_data
);

  logic [CntW-1:0] point_count;
  cmd_t  cmd;
  stat_t st;
  logic  busy;

  // Nothing is taken while in reset.
  assign in_stall  = busy || rst;
  assign cfg_ready = !rst;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) point_count <= '0;
    else if (cfg_valid && cfg_ready) point_count <= cfg_data;
  end

  pli_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req_type,
    .out_busy(out_valid && out_stall), .st, .cmd, .busy
  );

  pli_dpath u_dpath (
    .clk, .rst, .cmd,
    .load_we(in_valid && !in_stall && req_type == REQ_LOAD),
    .entry_index, .x_value, .y_value, .point_count, .out_stall,
    .st, .out_valid, .y_result, .status
  );

`ifndef SYNTH
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(y_result) && $stable(status))
    else $error("result changed while stalled");
  // A non-ok status always carries a zero value.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> y_result == '0)
    else $error("nonzero value with error status");
  // The block accepts nothing while busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("input accepted while busy");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the piecewise linear interpolator.
// Depends on pli_pkg and piecewise_linear_interpolator; compares each result
// with a behavioral interpolation of its own over a shadow breakpoint table.
module testbench;
  import pli_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 100;

  typedef struct {
    status_t st;
    logic signed [DataW-1:0] y;
  } lookup_t;

  typedef struct {
    logic do_cfg;
    logic [CntW-1:0] cnt;
    logic rt;
    logic [IdxW-1:0] idx;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic has_exp;
    status_t est;
    logic signed [DataW-1:0] ey;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_LOAD;
  logic [IdxW-1:0] entry_index = '0;
  logic signed [DataW-1:0] x_value = '0;
  logic signed [DataW-1:0] y_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DataW-1:0] y_result;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CntW-1:0] cfg_data = '0;

  // Shadow copy of the breakpoint table and the point count.
  logic signed [DataW-1:0] tab_x [MaxPoints];
  logic signed [DataW-1:0] tab_y [MaxPoints];
  int unsigned pt_count = 0;

  lookup_t pending_lookups[$];
  row_t directed_rows[$];
  int mismatches = 0;
  int cycles = 0;
  int n_evals = 0;
  int n_loads = 0;
  int n_counts = 0;
  int burst_left = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  piecewise_linear_interpolator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .entry_index(entry_index),
    .x_value(x_value), .y_value(y_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .y_result(y_result), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[piecewise_linear_interpolator] ERROR");
      $finish;
    end
  end

  // Linear interpolation over the shadow table, clamped as the block does.
  function automatic lookup_t interpolate(logic signed [DataW-1:0] q);
    lookup_t r;
    int n, first, len, half, mid, k;
    longint x_lo, x_hi, y_lo, y_hi, num, den, p, acc;
    r.st = ST_OK;
    r.y = '0;
    n = (pt_count > MaxPoints) ? MaxPoints : pt_count;
    if (n == 0) r.st = ST_EMPTY;
    else if (q < tab_x[0]) r.st = ST_BELOW;
    else if (q > tab_x[n-1]) r.st = ST_ABOVE;
    else if (q == tab_x[0]) r.y = tab_y[0];
    else if (q == tab_x[n-1]) r.y = tab_y[n-1];
    else begin
      first = 0;
      len = n;
      while (len > 0) begin
        half = len / 2;
        mid = first + half;
        if (tab_x[mid] < q) begin
          first = mid + 1;
          len = len - half - 1;
        end else begin
          len = half;
        end
      end
      k = (first < 1) ? 1 : first;
      if (k > n - 1) k = n - 1;
      x_lo = tab_x[k-1];
      x_hi = tab_x[k];
      y_lo = tab_y[k-1];
      y_hi = tab_y[k];
      den = x_hi - x_lo;
      num = longint'(q) - x_lo;
      if (den <= 0) begin
        r.y = y_lo[DataW-1:0];
      end else begin
        p = (num <= 0) ? 0 : (num <<< FracBits) / den;
        if (p > (64'sd1 <<< FracBits)) p = 64'sd1 <<< FracBits;
        acc = (((64'sd1 <<< FracBits) - p) * y_lo + p * y_hi) >>> FracBits;
        r.y = acc[DataW-1:0];
      end
    end
    return r;
  endfunction

  // Offer one item and wait for it to be taken; has_exp overrides the lookup.
  task automatic send_item(logic rt, logic [IdxW-1:0] idx, logic signed [DataW-1:0] x,
                           logic signed [DataW-1:0] y, logic has_exp = 1'b0,
                           status_t est = ST_OK, logic signed [DataW-1:0] ey = '0);
    lookup_t e;
    int gap;
    in_valid <= 1'b1;
    req_type <= rt;
    entry_index <= idx;
    x_value <= x;
    y_value <= y;
    do @(posedge clk); while (in_stall);
    if (rt == REQ_LOAD) begin
      tab_x[idx] = x;
      tab_y[idx] = y;
      n_loads++;
    end else begin
      e = interpolate(x);
      if (has_exp) begin
        e.st = est;
        e.y = ey;
      end
      pending_lookups.push_back(e);
      n_evals++;
    end
    // Bursts of back-to-back items separated by random gaps.
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom % 6 == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results, let any load finish, then write the point count.
  task automatic set_count(logic [CntW-1:0] value);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pt_count = value;
    n_counts++;
  endtask

  // Fill every slot with ascending x and random y.
  task automatic load_sorted_table();
    longint step, span, base;
    step = 1 + ($urandom % (($urandom % 2) ? 32'h3FF_FFFF : 32'hFFFF));
    span = 64'd4294967296 - 63 * step;
    base = -64'sd2147483648 + longint'({$urandom, $urandom} % span);
    for (int k = 0; k < MaxPoints; k++)
      send_item(REQ_LOAD, k[IdxW-1:0], DataW'(base + k * step), $urandom);
  endtask

  task automatic add_row(logic do_cfg, logic [CntW-1:0] cnt, logic rt,
                         logic [IdxW-1:0] idx, logic signed [DataW-1:0] x,
                         logic signed [DataW-1:0] y, logic has_exp,
                         status_t est, logic signed [DataW-1:0] ey);
    row_t r;
    r = '{do_cfg, cnt, rt, idx, x, y, has_exp, est, ey};
    directed_rows.push_back(r);
  endtask

  // Result checker.
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d y %h", status, y_result);
      end else begin
        e = pending_lookups.pop_front();
        if (status !== e.st || y_result !== e.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d y %h, got status %0d y %h",
                     e.st, e.y, status, y_result);
        end
      end
    end
  end

  // Receiver: changing stall patterns plus an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    if (mode_left == 0) begin
      mode_left <= $urandom_range(50, 300);
      stall_mode <= $urandom_range(0, 2);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_left > 0) out_stall <= 1'b1;
    else if (stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1) out_stall <= ($urandom % 4 == 0);
    else out_stall <= ($urandom % 4 != 0);
  end

  initial begin
    int n, r;
    longint lo, hi;
    logic signed [DataW-1:0] q;
    logic [CntW-1:0] counts [10] = '{64, 2, 127, 1, 33, 0, 64, 5, 100, 17};

    // Empty table, then a few extreme breakpoints and lookups on them.
    add_row(0, 0, REQ_EVAL, 0, 0, 32'h1234_5678, 1, ST_EMPTY, 0);
    add_row(0, 0, REQ_EVAL, 0, 32'sh8000_0000, 0, 1, ST_EMPTY, 0);
    add_row(0, 0, REQ_EVAL, 0, 32'sh7FFF_FFFF, 0, 1, ST_EMPTY, 0);
    add_row(0, 0, REQ_LOAD, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, ST_OK, 0);
    add_row(0, 0, REQ_LOAD, 1, 0, 32'sh8000_0000, 0, ST_OK, 0);
    add_row(0, 0, REQ_LOAD, 2, 32'sh0001_0000, 32'sh0001_0000, 0, ST_OK, 0);
    add_row(0, 0, REQ_LOAD, 3, 32'sh7FFF_FFFF, 0, 0, ST_OK, 0);
    add_row(0, 0, REQ_LOAD, 63, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, ST_OK, 0);
    add_row(1, 4, REQ_EVAL, 0, 32'sh8000_0000, 0, 1, ST_OK, 32'sh7FFF_FFFF);
    add_row(0, 0, REQ_EVAL, 0, 32'sh7FFF_FFFF, 0, 1, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, 0, 0, 0, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, 32'sh0000_8000, 0, 0, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, -1, 0, 0, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, 32'sh7FFF_FFFE, 0, 0, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, 32'sh0000_0001, 0, 0, ST_OK, 0);
    add_row(1, 3, REQ_EVAL, 0, 32'sh7FFF_FFFF, 0, 1, ST_ABOVE, 0);
    add_row(0, 0, REQ_LOAD, 0, -32'sh100, 5, 0, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, -32'sh101, 0, 1, ST_BELOW, 0);
    add_row(0, 0, REQ_EVAL, 0, -32'sh100, 0, 1, ST_OK, 5);
    // Unsorted table: the middle breakpoint sits above the last one.
    add_row(0, 0, REQ_LOAD, 1, 32'sh0002_0000, 7, 0, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, 32'sh0000_8000, 0, 0, ST_OK, 0);
    add_row(0, 0, REQ_EVAL, 0, 32'sh0000_FFFF, 0, 0, ST_OK, 0);

    for (int k = 0; k < MaxPoints; k++) begin
      tab_x[k] = '0;
      tab_y[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].do_cfg) set_count(directed_rows[i].cnt);
      send_item(directed_rows[i].rt, directed_rows[i].idx, directed_rows[i].x,
                directed_rows[i].y, directed_rows[i].has_exp,
                directed_rows[i].est, directed_rows[i].ey);
    end

    // Random part: full table loads, mostly in-range queries, some noise.
    load_sorted_table();
    for (int ph = 0; ph < 10; ph++) begin
      set_count(counts[ph]);
      if (ph % 2 == 1) load_sorted_table();
      if (ph == 3) hold_asked++;
      for (int it = 0; it < 70; it++) begin
        n = (pt_count > MaxPoints) ? MaxPoints : pt_count;
        r = $urandom % 100;
        if (r < 8) begin
          send_item(REQ_LOAD, IdxW'($urandom), DataW'($urandom), DataW'($urandom));
        end else begin
          q = $urandom;
          if (n > 0) begin
            lo = tab_x[0];
            hi = tab_x[n-1];
            if (r < 65 && hi >= lo) q = DataW'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
            else if (r < 78) q = tab_x[$urandom % n];
            else if (r < 84) q = DataW'(lo - 1);
            else if (r < 90) q = DataW'(hi + 1);
          end
          send_item(REQ_EVAL, IdxW'($urandom), q, DataW'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    $display("Covered %0d lookups and %0d breakpoint loads over %0d point counts,",
             n_evals, n_loads, n_counts);
    $display("including empty, oversized, unsorted and out-of-range tables; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("[piecewise_linear_interpolator] OK");
    end else begin
      $display("[piecewise_linear_interpolator] ERROR");
    end
    $finish;
  end

endmodule
